// File: src/pdu_pkg.sv
// ----------------------------------------------------------------------------
// pdu_pkg
// Shared types, constants and helpers for the percent decoder / UTF-8 checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pdu_pkg;

	// capacity limits
	localparam int MAX_CAPACITY = 1024;
	localparam int CAP_W        = 11;
	localparam int CNT_W        = 10;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd64;

	// verdict error codes
	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_ESCAPE   = 3'd1,
		ERR_ZERO     = 3'd2,
		ERR_CAPACITY = 3'd3,
		ERR_UTF8     = 3'd4
	} err_t;

	// one raw input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             done_res;
		logic             ok;
		logic [2:0]       err_code;
		logic [CNT_W-1:0] out_length;
	} out_item_t;

	// results produced by one item, in delivery order
	typedef struct packed {
		logic [1:0] n;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	// hex digit decode: {is_hex, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/percent_decoder_utf8_checker_core.sv
// ----------------------------------------------------------------------------
// percent_decoder_utf8_checker_core
// Form-value percent decoder with streaming UTF-8 validation.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one raw byte per item (or an end-only
//   item with has_byte low). out_valid/out_ready/out_data return decoded
//   byte items and, on an item marked last, one verdict item after them.
//   cfg_wr_en/cfg_wr_data set buffer_capacity; write only while idle.
//   An accepted item is held in the input register; the decode logic then
//   writes its results into the result queue, which offers them in order.
//   Throughput: one item per cycle while the result queue has space and each
//   item yields at most one result; an item yielding a byte and a verdict
//   pushes two results. An item leaves the input register only when at
//   least two of the four result queue slots are free.
//   When the receiver stalls, items keep flowing until the queue holds three
//   results; then the input register keeps its item, in_ready drops and
//   nothing is lost. Reset: capacity returns to 64, all per-value state is
//   cleared and the queue is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_decoder_utf8_checker_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire pdu_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output pdu_pkg::out_item_t              out_data,
	input  wire logic                       cfg_wr_en,
	input  wire logic [pdu_pkg::CAP_W-1:0]  cfg_wr_data
);

	logic [pdu_pkg::CAP_W-1:0] cap_q;
	logic                      valid_s1;
	pdu_pkg::in_item_t         item_s1;
	logic                      space;
	logic                      step;
	pdu_pkg::push_t            push;

	assign step     = valid_s1 && space;
	assign in_ready = !valid_s1 || step;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= pdu_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	pdu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cap    (cap_q),
		.push   (push)
	);

	pdu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_step_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> valid_s1)
		else $error("results pushed without an item");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while register empty");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !space |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a blocked item");

endmodule

`default_nettype wire

// File: src/pdu_decode.sv
// ----------------------------------------------------------------------------
// pdu_decode
// Per-value decode state, escape parsing, capacity check and UTF-8 tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_decode (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire pdu_pkg::in_item_t        item,
	input  wire logic [pdu_pkg::CAP_W-1:0] cap,
	output pdu_pkg::push_t                push
);

	typedef enum logic [2:0] {
		ESC_IDLE = 3'b001,
		ESC_HIGH = 3'b010,
		ESC_LOW  = 3'b100
	} esc_t;

	localparam logic [pdu_pkg::CAP_W-1:0] CAP_MAX = pdu_pkg::CAP_W'(pdu_pkg::MAX_CAPACITY);

	esc_t                      esc_q, esc_n;
	logic [3:0]                hi_q, hi_n;
	logic [pdu_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]                de_q, de_n;
	logic [1:0]                pend_q, pend_n;
	logic [20:0]               cp_q, cp_n;
	logic [1:0]                cls_q, cls_n;
	logic                      bad_q, bad_n;

	logic [4:0]                hex;
	logic [7:0]                value;
	logic                      produce;
	logic                      byte_out;
	logic [pdu_pkg::CAP_W-1:0] cap_eff;
	logic [20:0]               cp_min;
	logic [1:0]                de_fin;
	pdu_pkg::err_t             code;
	pdu_pkg::out_item_t        byte_res, verdict_res;

	assign hex     = pdu_pkg::hex_digit(item.data_byte);
	assign cap_eff = (cap > CAP_MAX) ? CAP_MAX : cap;

	// next state for one item
	always_comb begin
		esc_n    = esc_q;
		hi_n     = hi_q;
		cnt_n    = cnt_q;
		de_n     = de_q;
		pend_n   = pend_q;
		cp_n     = cp_q;
		cls_n    = cls_q;
		bad_n    = bad_q;
		value    = item.data_byte;
		produce  = 1'b0;
		byte_out = 1'b0;
		cp_min   = 21'h10000;
		if (item.has_byte && de_q == 2'd0) begin
			unique case (esc_q)
				ESC_HIGH: begin
					if (!hex[4]) begin
						de_n  = pdu_pkg::ERR_ESCAPE[1:0];
						esc_n = ESC_IDLE;
					end else begin
						hi_n  = hex[3:0];
						esc_n = ESC_LOW;
					end
				end
				ESC_LOW: begin
					esc_n = ESC_IDLE;
					if (!hex[4]) begin
						de_n = pdu_pkg::ERR_ESCAPE[1:0];
					end else begin
						value   = {hi_q, hex[3:0]};
						produce = 1'b1;
					end
				end
				default: begin
					esc_n = ESC_IDLE;
					if (item.data_byte == 8'h25) begin
						esc_n = ESC_HIGH;
					end else begin
						value   = (item.data_byte == 8'h2B) ? 8'h20 : item.data_byte;
						produce = 1'b1;
					end
				end
			endcase
			// emit, or refuse on zero byte or full buffer
			if (produce) begin
				priority if (value == 8'h00) begin
					de_n = pdu_pkg::ERR_ZERO[1:0];
				end else if ({1'b0, cnt_q} + 11'd1 >= cap_eff) begin
					de_n = pdu_pkg::ERR_CAPACITY[1:0];
				end else begin
					cnt_n    = cnt_q + 10'd1;
					byte_out = 1'b1;
					// utf-8 tracking on the decoded byte
					if (pend_q == 2'd0) begin
						priority if (!value[7]) begin
							bad_n = bad_q;
						end else if (value >= 8'hC2 && value <= 8'hDF) begin
							pend_n = 2'd1; cp_n = {16'd0, value[4:0]}; cls_n = 2'd1;
						end else if (value >= 8'hE0 && value <= 8'hEF) begin
							pend_n = 2'd2; cp_n = {17'd0, value[3:0]}; cls_n = 2'd2;
						end else if (value >= 8'hF0 && value <= 8'hF4) begin
							pend_n = 2'd3; cp_n = {18'd0, value[2:0]}; cls_n = 2'd3;
						end else begin
							bad_n = 1'b1;
						end
					end else if (value[7:6] != 2'b10) begin
						bad_n  = 1'b1;
						pend_n = 2'd0;
					end else begin
						cp_n   = {cp_q[14:0], value[5:0]};
						pend_n = pend_q - 2'd1;
						if (pend_q == 2'd1) begin
							cp_min = (cls_q == 2'd1) ? 21'h80 :
							         (cls_q == 2'd2) ? 21'h800 : 21'h10000;
							if (cp_n < cp_min || cp_n > 21'h10FFFF ||
							    (cp_n >= 21'hD800 && cp_n <= 21'hDFFF)) begin
								bad_n = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// verdict for the value
	always_comb begin
		de_fin = de_n;
		if (de_n == 2'd0 && esc_n != ESC_IDLE) begin
			de_fin = pdu_pkg::ERR_ESCAPE[1:0];
		end
		priority if (de_fin != 2'd0) begin
			code = pdu_pkg::err_t'({1'b0, de_fin});
		end else if (bad_n || pend_n != 2'd0) begin
			code = pdu_pkg::ERR_UTF8;
		end else begin
			code = pdu_pkg::ERR_NONE;
		end
	end

	// result items
	always_comb begin
		byte_res            = '0;
		byte_res.out_byte   = value;
		byte_res.byte_valid = 1'b1;
		byte_res.out_length = cnt_n;

		verdict_res            = '0;
		verdict_res.done_res   = 1'b1;
		verdict_res.ok         = (code == pdu_pkg::ERR_NONE);
		verdict_res.err_code   = code;
		verdict_res.out_length = cnt_n;

		push.n      = step ? ({1'b0, byte_out} + {1'b0, item.last}) : 2'd0;
		push.first  = byte_out ? byte_res : verdict_res;
		push.second = verdict_res;
	end

	// state registers, cleared at the end of each value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= ESC_IDLE;
			hi_q   <= '0;
			cnt_q  <= '0;
			de_q   <= '0;
			pend_q <= '0;
			cp_q   <= '0;
			cls_q  <= '0;
			bad_q  <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				esc_q  <= ESC_IDLE;
				hi_q   <= '0;
				cnt_q  <= '0;
				de_q   <= '0;
				pend_q <= '0;
				cp_q   <= '0;
				cls_q  <= '0;
				bad_q  <= 1'b0;
			end else begin
				esc_q  <= esc_n;
				hi_q   <= hi_n;
				cnt_q  <= cnt_n;
				de_q   <= de_n;
				pend_q <= pend_n;
				cp_q   <= cp_n;
				cls_q  <= cls_n;
				bad_q  <= bad_n;
			end
		end
	end

	// value end returns all per-value state to idle
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last |=> cnt_q == '0 && de_q == 2'd0 && esc_q == ESC_IDLE && pend_q == 2'd0)
		else $error("state not cleared after last item");

	// a decode error freezes the byte count until the value ends
	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		de_q != 2'd0 && !(step && item.last) |=> $stable(cnt_q))
		else $error("byte count moved after decode error");

	// the count stays below the effective capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 || {1'b0, cnt_q} < cap_eff)
		else $error("byte count beyond capacity");

endmodule

`default_nettype wire

// File: src/pdu_out_fifo.sv
// ----------------------------------------------------------------------------
// pdu_out_fifo
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pdu_pkg::push_t     push,
	output logic                    space,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pdu_pkg::out_item_t      out_data
);

	pdu_pkg::out_item_t mem_q [4];
	logic [1:0]         wp_q, rp_q;
	logic [2:0]         cnt_q;
	logic               pop;
	logic [1:0]         wp1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = mem_q[rp_q];
	assign space     = (cnt_q <= 3'd2);
	assign wp1       = wp_q + 2'd1;

	// storage writes
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wp1] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push.n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} + {2'b00, push.n} <= 4'd4)
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");

	a_double_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |=> cnt_q >= 3'd2)
		else $error("double push lost an item");

endmodule

`default_nettype wire

// File: dv/percent_decoder_utf8_checker_core_tb.sv
// ----------------------------------------------------------------------------
// percent_decoder_utf8_checker_core_tb
// Self-checking bench for the form-value decoder. Raw encoded bytes go in,
// a scoreboard predicts every decoded byte and the per-value verdict, and
// each result is checked against it under varied capacity and idling.
// ----------------------------------------------------------------------------
module percent_decoder_utf8_checker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int TIMEOUT_NS   = 2_000_000;

	// characters with a meaning to the decoder
	localparam logic [7:0] BYTE_PCT     = 8'h25;
	localparam logic [7:0] BYTE_PLUS    = 8'h2B;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HIGH = 2'd2
	} esc_t;

	// decoder model plus the queue of results it still owes
	class decode_scoreboard;
		logic [pdu_pkg::CAP_W-1:0] capacity;
		esc_t                      esc_phase;
		logic [3:0]                high_nib;
		int                        dec_count;
		pdu_pkg::err_t             dec_err;
		int                        cont_left;
		logic [20:0]               codepoint;
		int                        min_class;
		bit                        utf8_bad;
		pdu_pkg::out_item_t        predicted_out[$];
		int                        items_in;
		int                        bytes_out;
		int                        verdicts;
		int                        verdicts_ok;
		int                        fails;

		function new();
			capacity = pdu_pkg::CAP_RESET;
			clear_value();
		endfunction

		function void clear_value();
			esc_phase = ESC_IDLE;
			high_nib  = 4'd0;
			dec_count = 0;
			dec_err   = pdu_pkg::ERR_NONE;
			cont_left = 0;
			codepoint = '0;
			min_class = 0;
			utf8_bad  = 1'b0;
		endfunction

		function void set_capacity(logic [pdu_pkg::CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
			return -1;
		endfunction

		// streaming utf-8 check of one decoded byte
		function void feed_utf8(logic [7:0] b);
			int unsigned floor_cp;
			if (cont_left == 0) begin
				if (b >= 8'hC2 && b <= 8'hDF) begin
					cont_left = 1;
					codepoint = {16'd0, b[4:0]};
					min_class = 1;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					cont_left = 2;
					codepoint = {17'd0, b[3:0]};
					min_class = 2;
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					cont_left = 3;
					codepoint = {18'd0, b[2:0]};
					min_class = 3;
				end else if (b > 8'h7F) begin
					utf8_bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				utf8_bad  = 1'b1;
				cont_left = 0;
			end else begin
				codepoint = {codepoint[14:0], b[5:0]};
				cont_left--;
				// overlong, above the last code point, or surrogate
				if (cont_left == 0) begin
					floor_cp = (min_class == 1) ? 'h80 : (min_class == 2) ? 'h800 : 'h10000;
					if (codepoint < floor_cp || codepoint > 21'h10FFFF ||
							(codepoint >= 21'h00D800 && codepoint <= 21'h00DFFF)) begin
						utf8_bad = 1'b1;
					end
				end
			end
		endfunction

		// predict the results of one accepted item
		function void note_item(pdu_pkg::in_item_t it);
			logic [7:0]         value;
			int                 nib;
			int                 cap;
			bit                 produce;
			pdu_pkg::err_t      code;
			pdu_pkg::out_item_t r;
			items_in++;
			produce = 1'b0;
			value   = it.data_byte;
			if (it.has_byte && dec_err == pdu_pkg::ERR_NONE) begin
				case (esc_phase)
					ESC_PCT: begin
						nib = nibble_of(value);
						if (nib < 0) begin
							dec_err   = pdu_pkg::ERR_ESCAPE;
							esc_phase = ESC_IDLE;
						end else begin
							high_nib  = nib[3:0];
							esc_phase = ESC_HIGH;
						end
					end
					ESC_HIGH: begin
						nib = nibble_of(value);
						esc_phase = ESC_IDLE;
						if (nib < 0) begin
							dec_err = pdu_pkg::ERR_ESCAPE;
						end else begin
							value   = {high_nib, nib[3:0]};
							produce = 1'b1;
						end
					end
					default: begin
						esc_phase = ESC_IDLE;
						if (value == BYTE_PCT) begin
							esc_phase = ESC_PCT;
						end else begin
							if (value == BYTE_PLUS) value = BYTE_SPACE;
							produce = 1'b1;
						end
					end
				endcase
				if (produce) begin
					cap = (capacity > pdu_pkg::MAX_CAPACITY) ? pdu_pkg::MAX_CAPACITY
						: int'(capacity);
					if (value == 8'h00) begin
						dec_err = pdu_pkg::ERR_ZERO;
					end else if (dec_count + 1 >= cap) begin
						dec_err = pdu_pkg::ERR_CAPACITY;
					end else begin
						dec_count++;
						feed_utf8(value);
						r = '0;
						r.out_byte   = value;
						r.byte_valid = 1'b1;
						r.out_length = pdu_pkg::CNT_W'(dec_count);
						predicted_out.push_back(r);
					end
				end
			end
			// verdict, with an unfinished escape counted as a bad escape
			if (it.last) begin
				if (dec_err == pdu_pkg::ERR_NONE && esc_phase != ESC_IDLE)
					dec_err = pdu_pkg::ERR_ESCAPE;
				if (dec_err != pdu_pkg::ERR_NONE) code = dec_err;
				else if (utf8_bad || cont_left != 0) code = pdu_pkg::ERR_UTF8;
				else code = pdu_pkg::ERR_NONE;
				r = '0;
				r.done_res   = 1'b1;
				r.ok         = (code == pdu_pkg::ERR_NONE);
				r.err_code   = code;
				r.out_length = pdu_pkg::CNT_W'(dec_count);
				predicted_out.push_back(r);
				clear_value();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_item(pdu_pkg::out_item_t got);
			pdu_pkg::out_item_t want;
			if (predicted_out.size() == 0) begin
				$error("result with nothing owed: out_byte 0x%0h done_res %0b",
					got.out_byte, got.done_res);
				fails++;
				return;
			end
			want = predicted_out.pop_front();
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("byte_valid", want.byte_valid, got.byte_valid);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("ok", want.ok, got.ok);
			compare_field("err_code", want.err_code, got.err_code);
			compare_field("out_length", want.out_length, got.out_length);
			if (want.done_res) begin
				verdicts++;
				if (want.ok) verdicts_ok++;
			end else begin
				bytes_out++;
			end
		endfunction
	endclass

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	pdu_pkg::in_item_t         in_data     = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	pdu_pkg::out_item_t        out_data;
	logic                      cfg_wr_en   = 1'b0;
	logic [pdu_pkg::CAP_W-1:0] cfg_wr_data = '0;

	decode_scoreboard  sb;
	pdu_pkg::in_item_t stim_q[$];
	int                send_pct  = 0;
	int                stall_pct = 0;
	bit                hold_off  = 1'b0;
	int                caps_written = 0;

	percent_decoder_utf8_checker_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiving side: random stalls, long hold-off on request
	always begin
		@(negedge clk);
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		@(posedge clk);
		if (out_valid === 1'b1 && out_ready) sb.check_item(out_data);
	end

	// stimulus building
	function automatic void push_item(logic [7:0] b, logic has, logic lst);
		pdu_pkg::in_item_t it;
		it.data_byte = b;
		it.has_byte  = has;
		it.last      = lst;
		stim_q.push_back(it);
	endfunction

	function automatic void push_raw(logic [7:0] b);
		push_item(b, 1'b1, 1'b0);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return CHAR_0 + n;
		return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + n - 8'd10;
	endfunction

	function automatic void push_escaped(logic [7:0] b);
		push_raw(BYTE_PCT);
		push_raw(hex_char(b[7:4]));
		push_raw(hex_char(b[3:0]));
	endfunction

	// a byte as itself or as an escape; '%' and '+' always escaped
	function automatic void push_any(logic [7:0] b);
		if (b == BYTE_PCT || b == BYTE_PLUS || $urandom_range(2) == 0) push_escaped(b);
		else push_raw(b);
	endfunction

	// one well-formed multi-byte char
	function automatic void push_codepoint();
		logic [20:0] cp;
		case ($urandom_range(2))
			0: cp = 21'($urandom_range('h80, 'h7FF));
			1: begin
				cp = 21'($urandom_range('h800, 'hF7FF));
				if (cp >= 21'h00D800) cp = cp + 21'h000800;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		if (cp < 21'h000800) begin
			push_any({3'b110, cp[10:6]});
			push_any({2'b10, cp[5:0]});
		end else if (cp < 21'h010000) begin
			push_any({4'b1110, cp[15:12]});
			push_any({2'b10, cp[11:6]});
			push_any({2'b10, cp[5:0]});
		end else begin
			push_any({5'b11110, cp[20:18]});
			push_any({2'b10, cp[17:12]});
			push_any({2'b10, cp[11:6]});
			push_any({2'b10, cp[5:0]});
		end
	endfunction

	// mostly well-formed content, some noise and broken escapes
	function automatic void push_token();
		int kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			push_any(8'($urandom_range('h20, 'h7E)));
		end else if (kind < 43) begin
			push_raw(BYTE_PLUS);
		end else if (kind < 75) begin
			push_codepoint();
		end else if (kind < 85) begin
			push_escaped(8'($urandom_range(1, 127)));
		end else if (kind < 90) begin
			push_item(8'($urandom), 1'b0, 1'b0);
		end else if (kind < 96) begin
			push_raw(8'($urandom_range(255)));
		end else begin
			push_raw(BYTE_PCT);
			if ($urandom_range(1)) push_raw(hex_char(4'($urandom_range(15))));
			push_raw(8'($urandom_range('h67, 'h7A)));
		end
	endfunction

	// close the value on its last byte or with an end-only item
	function automatic void end_value();
		if (stim_q.size() != 0 && stim_q[$].has_byte && $urandom_range(2) != 0)
			stim_q[$].last = 1'b1;
		else
			push_item(8'($urandom), 1'b0, 1'b1);
	endfunction

	// offer one item; called and returns at a falling edge
	task automatic send_item(input pdu_pkg::in_item_t it);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_stim();
		foreach (stim_q[i]) send_item(stim_q[i]);
		stim_q.delete();
	endtask

	// wait until the block has drained, then write the capacity
	task automatic write_capacity(input logic [pdu_pkg::CAP_W-1:0] cap);
		in_valid <= 1'b0;
		while (sb.predicted_out.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(cap);
		caps_written++;
	endtask

	task automatic run_phase(input logic [pdu_pkg::CAP_W-1:0] cap, input int send_p,
			input int stall_p, input int n_items, input bit hold);
		int stop_at;
		write_capacity(cap);
		@(posedge clk);
		send_pct  = send_p;
		stall_pct = stall_p;
		// long receiver hold-off while items keep coming
		if (hold) begin
			fork
				begin
					repeat (20) @(posedge clk);
					hold_off = 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_off = 1'b0;
				end
			join_none
		end
		@(negedge clk);
		stop_at = sb.items_in + n_items;
		while (sb.items_in < stop_at) begin
			repeat ($urandom_range(8)) push_token();
			end_value();
			send_stim();
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed values at the reset capacity
		// plus and a lower-case escape
		push_raw(BYTE_PLUS); push_raw(BYTE_PCT); push_raw("4"); push_item("f", 1'b1, 1'b1);
		// empty item, bad lead, then a bad escape that outranks it
		push_item(8'h00, 1'b0, 1'b0);
		push_raw(8'hFF); push_raw(BYTE_PCT); push_item("z", 1'b1, 1'b1);
		// escape cut short by the end
		push_raw(BYTE_PCT); push_raw("e"); push_item(8'hFF, 1'b0, 1'b1);
		// decoded zero byte
		push_raw(BYTE_PCT); push_raw("0"); push_item("0", 1'b1, 1'b1);
		// overlong three-byte form
		push_raw(8'hE0); push_raw(8'h80); push_item(8'h80, 1'b1, 1'b1);
		// surrogate
		push_raw(8'hED); push_raw(8'hA0); push_item(8'h80, 1'b1, 1'b1);
		// above the last code point
		push_raw(8'hF4); push_raw(8'h90); push_raw(8'h80); push_item(8'h80, 1'b1, 1'b1);
		// lead followed by a non-continuation
		push_raw(8'hC3); push_item(8'h41, 1'b1, 1'b1);
		// sequence still open at the end
		push_raw(8'hC3); push_item(8'h00, 1'b0, 1'b1);
		send_stim();

		// random phases over capacity and idling
		run_phase(11'd1024, 0, 0, 120, 1'b1);
		run_phase(11'd5, 57, 0, 100, 1'b0);
		run_phase(11'd16, 0, 57, 100, 1'b0);
		run_phase(11'd1, 37, 37, 60, 1'b0);
		run_phase(11'd0, 37, 37, 40, 1'b0);
		run_phase(pdu_pkg::CAP_W'($urandom_range(2, 40)), 37, 37, 100, 1'b0);
		run_phase(11'd2047, 0, 0, 40, 1'b0);

		in_valid <= 1'b0;
		while (sb.predicted_out.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d input items, %0d decoded bytes, %0d verdicts (%0d clean)",
			sb.items_in, sb.bytes_out, sb.verdicts, sb.verdicts_ok);
		$display("%0d capacity writes, from zero up to an out-of-range value", caps_written);
		if (sb.fails == 0) begin
			$display("percent_decoder_utf8_checker_core_tb passed");
		end else begin
			$display("percent_decoder_utf8_checker_core_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#TIMEOUT_NS;
		$display("percent_decoder_utf8_checker_core_tb failed");
		$finish;
	end

endmodule
